// ===== design/periodic_stream_scheduler_macros.svh =====
// Assertion macros shared by the periodic stream scheduler RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef PERIODIC_STREAM_SCHEDULER_MACROS_SVH
`define PERIODIC_STREAM_SCHEDULER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pss_pkg.sv =====
// Shared types and constants of the periodic stream scheduler.
// No dependencies; imported by the front, back and top-level modules.
package pss_pkg;

    localparam int unsigned LEN_LIMIT    = 1500;
    localparam int unsigned RUN_RESET    = 700;
    localparam int unsigned SC_RESET     = 1;
    localparam int unsigned RESULT_LIMIT = 16;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int TICK_W     = 16;
    localparam int IDX_W      = 4;
    localparam int LEN_W      = 11;
    localparam int PIN_W      = 11;
    localparam int PSTORE_W   = 16;
    localparam int SC_W       = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LENGTH   = 8'd1;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic [SC_W-1:0]   stream_count;
        logic [TICK_W-1:0] run_length;
    } cfg_t;

    typedef struct packed {
        logic                is_tick;
        logic [IDX_W-1:0]    idx;
        logic [PSTORE_W-1:0] period;
        logic [LEN_W-1:0]    length;
        logic [TICK_W-1:0]   tick;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]  due_index;
        logic [LEN_W-1:0]  due_length;
        logic [TICK_W-1:0] tick_number;
        logic              last;
    } res_t;

endpackage

// ===== design/pss_fifo.sv =====
// Small synchronous FIFO used for the command and result queues.
// No dependencies.
module pss_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== design/pss_front.sv =====
// Front end: accepts items, clamps load fields, drops dead items and owns the tick count.
// Depends on pss_pkg; feeds commands into the command queue.
module pss_front #(
    parameter int MAX_STREAMS = 16,
    parameter int PERIOD_MAX  = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic                         req_type,
    input  logic [pss_pkg::IDX_W-1:0]    stream_index,
    input  logic [pss_pkg::PIN_W-1:0]    period,
    input  logic [pss_pkg::LEN_W-1:0]    msg_length,
    input  logic                         cmd_full,
    input  pss_pkg::cfg_t                cfg,
    output logic                         cmd_push,
    output pss_pkg::cmd_t                cmd
);

    import pss_pkg::*;

    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [TICK_W-1:0] tick_inc;
    logic [16:0]       per_ext, per_clamp;
    logic              in_fire, is_tick, idx_ok, tick_run;

    assign in_fire  = push && !cmd_full;
    assign is_tick  = (req_type == REQ_TICK);
    assign idx_ok   = 7'(stream_index) < 7'(MAX_STREAMS);
    assign tick_run = tick_reg < cfg.run_length;
    assign tick_inc = tick_reg + TICK_W'(1);

    assign per_ext   = 17'(period);
    assign per_clamp = (per_ext > 17'(PERIOD_MAX)) ? 17'(PERIOD_MAX) : per_ext;

    // A tick past the run length and a load outside the table leave no command behind.
    assign cmd_push = in_fire && (is_tick ? tick_run : idx_ok);

    always_comb
    begin
        cmd.is_tick = is_tick;
        cmd.idx     = stream_index;
        cmd.period  = per_clamp[PSTORE_W-1:0];
        cmd.length  = (msg_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : msg_length;
        cmd.tick    = is_tick ? tick_inc : tick_reg;
    end

    assign tick_next = (in_fire && is_tick && tick_run) ? tick_inc : tick_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
        end
        else
        begin
            tick_reg <= tick_next;
        end
    end

endmodule

// ===== design/pss_back.sv =====
// Back end: stream table, remainder unit for loads and the per-tick table walk.
// Depends on pss_pkg and the assertion macros; pushes results into the result queue.
`include "periodic_stream_scheduler_macros.svh"

module pss_back #(
    parameter int MAX_STREAMS = 16,
    parameter int PERIOD_MAX  = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_empty,
    input  pss_pkg::cmd_t cmd,
    output logic          cmd_pop,
    input  pss_pkg::cfg_t cfg,
    input  logic          out_full,
    output logic          out_push,
    output pss_pkg::res_t out_data
);

    import pss_pkg::*;

    localparam int PW = $clog2(PERIOD_MAX + 1);
    localparam int IW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
    localparam int BW = $clog2(TICK_W);
    localparam int ACT_LIMIT = (MAX_STREAMS < RESULT_LIMIT) ? MAX_STREAMS : RESULT_LIMIT;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]    state_reg, state_next;
    cmd_t          cur_reg, cur_next;
    logic [BW-1:0] bit_reg, bit_next;
    logic [PW-1:0] div_rem_reg, div_rem_next;
    logic [IW-1:0] widx_reg, widx_next;
    logic          pend_valid_reg, pend_valid_next;
    res_t          pend_reg, pend_next;

    logic [PW-1:0] period_tab_reg [MAX_STREAMS];
    logic [LEN_W-1:0] len_tab_reg [MAX_STREAMS];
    logic [PW-1:0] rem_tab_reg [MAX_STREAMS];

    // Remainder unit: one quotient bit of tick / period per cycle.
    logic [PW:0]   shifted, diff, p_wide;
    logic [PW-1:0] div_rem_new;
    logic [PW-1:0] p_cur;
    logic          div_done;
    logic [IW-1:0] ld_idx;

    // Walk: every entry keeps tick mod period, so a stream is due when it wraps to zero.
    logic [PW-1:0] w_p, w_r, w_inc, w_new;
    logic [6:0]    active;
    logic          w_due, w_stall, walk_step;
    res_t          w_res;

    assign p_cur       = cur_reg.period[PW-1:0];
    assign p_wide      = {1'b0, p_cur};
    assign shifted     = {div_rem_reg, cur_reg.tick[bit_reg]};
    assign diff        = shifted - p_wide;
    assign div_rem_new = (shifted >= p_wide) ? diff[PW-1:0] : shifted[PW-1:0];
    assign div_done    = (state_reg == ST_DIV) && (bit_reg == '0);
    assign ld_idx      = IW'(cur_reg.idx);

    assign active = (7'(cfg.stream_count) < 7'(ACT_LIMIT)) ? 7'(cfg.stream_count)
                                                           : 7'(ACT_LIMIT);

    assign w_p     = period_tab_reg[widx_reg];
    assign w_r     = rem_tab_reg[widx_reg];
    assign w_inc   = w_r + PW'(1);
    assign w_new   = (w_inc == w_p) ? '0 : w_inc;
    assign w_due   = (w_p != '0) && (w_inc == w_p) && (7'(widx_reg) < active);
    assign w_stall = w_due && pend_valid_reg && out_full;

    always_comb
    begin
        w_res.due_index   = IDX_W'(widx_reg);
        w_res.due_length  = len_tab_reg[widx_reg];
        w_res.tick_number = cur_reg.tick;
        w_res.last        = 1'b0;
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        bit_next        = bit_reg;
        div_rem_next    = div_rem_reg;
        widx_next       = widx_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        cmd_pop         = 1'b0;
        out_push        = 1'b0;
        out_data        = pend_reg;
        walk_step       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop  = 1'b1;
                    cur_next = cmd;
                    if (cmd.is_tick)
                    begin
                        widx_next       = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_WALK;
                    end
                    else
                    begin
                        bit_next     = BW'(TICK_W - 1);
                        div_rem_next = '0;
                        state_next   = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                div_rem_next = div_rem_new;
                if (bit_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    bit_next = bit_reg - BW'(1);
                end
            end
            ST_WALK:
            begin
                if (!w_stall)
                begin
                    walk_step = 1'b1;
                    if (w_due)
                    begin
                        // The previous due stream is known not to be the last one.
                        out_push        = pend_valid_reg;
                        pend_next       = w_res;
                        pend_valid_next = 1'b1;
                    end
                    if (widx_reg == IW'(MAX_STREAMS - 1))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        widx_next = widx_reg + IW'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                out_data.last = 1'b1;
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!out_full)
                begin
                    out_push        = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        bit_reg     <= bit_next;
        div_rem_reg <= div_rem_next;
        widx_reg    <= widx_next;
        pend_reg    <= pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_STREAMS; i++)
            begin
                period_tab_reg[i] <= PW'(1);
                len_tab_reg[i]    <= LEN_W'(LEN_LIMIT);
                rem_tab_reg[i]    <= '0;
            end
        end
        else
        begin
            if (div_done)
            begin
                period_tab_reg[ld_idx] <= p_cur;
                len_tab_reg[ld_idx]    <= cur_reg.length;
                rem_tab_reg[ld_idx]    <= div_rem_new;
            end
            else if (walk_step)
            begin
                rem_tab_reg[widx_reg] <= w_new;
            end
        end
    end

    `PSS_ASSERT_SAME(a_no_push_when_full, clk, rst_n, out_push, !out_full,
        "result pushed into a full queue")
    `PSS_ASSERT_SAME(a_idle_no_pending, clk, rst_n, state_reg == ST_IDLE, !pend_valid_reg,
        "pending result left over after a tick")
    `PSS_ASSERT_SAME(a_last_only_in_flush, clk, rst_n, out_push && out_data.last,
        state_reg == ST_FLUSH, "last flag raised outside the end of a walk")
    `PSS_ASSERT_NEXT(a_div_exits_to_idle, clk, rst_n, state_reg == ST_DIV,
        state_reg == ST_DIV || state_reg == ST_IDLE, "remainder unit left to a wrong state")

endmodule

// ===== design/periodic_stream_scheduler.sv =====
// Periodic stream scheduler: loads stream entries and, on each tick, lists the due streams.
// A load item passes through the command queue into the back end, where a
// 16-step remainder unit works out the current tick modulo the new period one bit a cycle.
// A tick item walks the whole table one entry a cycle, but can pause while the result queue
// is full. Items that give nothing (ticks past the run length, loads outside the table) are
// dropped in the front end. Reset needs no clearing pass.
// Depends on pss_pkg, pss_front, pss_fifo and pss_back.
module periodic_stream_scheduler #(
    parameter int MAX_STREAMS = 16,
    parameter int PERIOD_MAX  = 1024,
    parameter int CMD_DEPTH   = 2,
    parameter int OUT_DEPTH   = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              req_type,
    input  logic [pss_pkg::IDX_W-1:0]         stream_index,
    input  logic [pss_pkg::PIN_W-1:0]         period,
    input  logic [pss_pkg::LEN_W-1:0]         msg_length,
    output logic                              empty,
    input  logic                              pop,
    output logic [pss_pkg::IDX_W-1:0]         due_index,
    output logic [pss_pkg::LEN_W-1:0]         due_length,
    output logic [pss_pkg::TICK_W-1:0]        tick_number,
    output logic                              last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pss_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import pss_pkg::*;

    cfg_t cfg_reg, cfg_next;
    cmd_t front_cmd, back_cmd;
    res_t back_res, out_res;
    logic front_push, cmd_full, cmd_empty, cmd_pop;
    logic res_push, res_full;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_STREAM_COUNT: cfg_next.stream_count = cfg_data[SC_W-1:0];
                CFG_RUN_LENGTH:   cfg_next.run_length   = cfg_data[TICK_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stream_count <= SC_W'(SC_RESET);
            cfg_reg.run_length   <= TICK_W'(RUN_RESET);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pss_front #(
        .MAX_STREAMS (MAX_STREAMS),
        .PERIOD_MAX  (PERIOD_MAX)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .req_type     (req_type),
        .stream_index (stream_index),
        .period       (period),
        .msg_length   (msg_length),
        .cmd_full     (cmd_full),
        .cfg          (cfg_reg),
        .cmd_push     (front_push),
        .cmd          (front_cmd)
    );

    assign full = cmd_full;

    pss_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (front_push),
        .wr_data (front_cmd),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .rd_data (back_cmd),
        .empty   (cmd_empty)
    );

    pss_back #(
        .MAX_STREAMS (MAX_STREAMS),
        .PERIOD_MAX  (PERIOD_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (back_cmd),
        .cmd_pop   (cmd_pop),
        .cfg       (cfg_reg),
        .out_full  (res_full),
        .out_push  (res_push),
        .out_data  (back_res)
    );

    pss_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (OUT_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (back_res),
        .full    (res_full),
        .pop     (pop),
        .rd_data (out_res),
        .empty   (empty)
    );

    assign due_index   = out_res.due_index;
    assign due_length  = out_res.due_length;
    assign tick_number = out_res.tick_number;
    assign last        = out_res.last;

endmodule
